// ===== sv/b32d_pkg.sv =====
// shared types, constants and the character classifier for the base32 decoder
`default_nettype none

package b32d_pkg;

  localparam int COUNT_BITS_DEF = 16;
  // result queue depth, power of two, room for two items in flight
  localparam int RES_DEPTH = 8;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // class codes above the 0..31 symbol values
  localparam logic [5:0] CLS_SPACE = 6'd32;
  localparam logic [5:0] CLS_PAD   = 6'd33;
  localparam logic [5:0] CLS_BAD   = 6'd34;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        status;
    logic [15:0] byte_count;
  } res_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic [5:0] classify(input logic [7:0] c);
    logic [5:0] cls;
    cls = CLS_BAD;
    if (c >= 8'h41 && c <= 8'h5A) begin
      cls = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      cls = 6'(c - 8'h61);
    end else if (c >= 8'h32 && c <= 8'h37) begin
      cls = 6'(c - 8'h32 + 8'd26);
    end else if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
      cls = CLS_SPACE;
    end else if (c == PAD_CHAR) begin
      cls = CLS_PAD;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== sv/b32d_if.sv =====
// valid/ready channel interfaces for input words and result words
`default_nettype none

interface b32d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b32d_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic        status;
  logic [15:0] byte_count;

  modport source (output valid, output kind, output data_byte, output status,
                  output byte_count, input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input byte_count, output ready);
endinterface

`default_nettype wire

// ===== sv/base32_stream_decoder.sv =====
// base32 stream decoder top level: input channel, decode core, result queue
// Usage:
//   in_ch carries one character word per handshake (char_code, end_of_text).
//   Letters of either case and digits 2-7 decode to five bits each; every
//   completed byte leaves on out_ch as a data word (kind 0). The word marked
//   end_of_text also produces a status word (kind 1) with the error flag and
//   the saturated byte count, after any data byte it completes.
//   Path: an accepted input word passes the input register and then the
//   result queue before its results appear on out_ch.
//   Throughput: one input word per cycle while in_ch ready stays high; a
//   final word that also completes a byte yields two results, which leave
//   the single-ported output of the result queue one after the other.
//   Reset (rst_n low, synchronous) empties the queue and clears the residue,
//   padding, error and byte count state.
//   When the receiver stalls, results collect in an eight-entry queue; in_ch
//   ready drops once fewer than four free entries remain after the word in
//   progress, so nothing is lost.
`default_nettype none

module base32_stream_decoder #(
  parameter int COUNT_BITS = b32d_pkg::COUNT_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  b32d_in_if.sink     in_ch,
  b32d_out_if.source  out_ch
);

  localparam int DEPTH = b32d_pkg::RES_DEPTH;
  localparam int CW    = $clog2(DEPTH + 1);

  logic            in_fire;
  logic            busy;
  logic            pop;
  logic            not_empty;
  logic [CW-1:0]   count;
  logic [CW:0]     reserved;
  b32d_pkg::push_t push;
  b32d_pkg::res_t  res_a, res_b, head;

  // keep room for the word in the input register plus a new one
  assign reserved    = (CW+1)'(count) + (busy ? (CW+1)'(2) : (CW+1)'(0));
  assign in_ch.ready = (reserved <= (CW+1)'(DEPTH - 4));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  b32d_decode_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_char (in_ch.char_code),
    .in_eot  (in_ch.end_of_text),
    .busy    (busy),
    .push    (push),
    .res_a   (res_a),
    .res_b   (res_b)
  );

  b32d_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .count     (count)
  );

  assign out_ch.valid      = not_empty;
  assign out_ch.kind       = head.kind;
  assign out_ch.data_byte  = head.data_byte;
  assign out_ch.status     = head.status;
  assign out_ch.byte_count = head.byte_count;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(DEPTH))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second result pushed without first");

  a_eot_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.end_of_text) |=> push.first)
    else $error("end of message produced no status word");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> (res_b.kind == b32d_pkg::KIND_STATUS &&
                     res_a.kind == b32d_pkg::KIND_DATA))
    else $error("two results out of order");

endmodule

`default_nettype wire

// ===== sv/b32d_decode_core.sv =====
// input register, decode state and per-word result generation
`default_nettype none

module b32d_decode_core #(
  parameter int COUNT_BITS = b32d_pkg::COUNT_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic [7:0]     in_char,
  input  wire logic           in_eot,
  output logic                busy,
  output b32d_pkg::push_t     push,
  output b32d_pkg::res_t      res_a,
  output b32d_pkg::res_t      res_b
);

  logic                  s1_valid_r;
  logic [7:0]            s1_char_r;
  logic                  s1_eot_r;

  logic [6:0]            residue_bits_r, residue_bits_nxt;
  logic [2:0]            residue_count_r, residue_count_nxt;
  logic                  padding_seen_r, padding_seen_nxt;
  logic                  error_flag_r, error_flag_nxt;
  logic [COUNT_BITS-1:0] bytes_out_r, bytes_out_nxt;

  logic [5:0]            cls;
  logic [11:0]           sh_buf;
  logic [3:0]            sh_cnt;
  logic                  data_hit;
  logic [7:0]            byte_val;
  logic                  err_seen;
  logic [COUNT_BITS-1:0] bytes_seen;
  logic [15:0]           rep_count;

  assign busy = s1_valid_r;
  assign cls  = b32d_pkg::classify(s1_char_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
    if (in_fire) begin
      s1_char_r <= in_char;
      s1_eot_r  <= in_eot;
    end
  end

  always_comb begin
    err_seen       = error_flag_r;
    bytes_seen     = bytes_out_r;
    residue_bits_nxt  = residue_bits_r;
    residue_count_nxt = residue_count_r;
    padding_seen_nxt  = padding_seen_r;
    sh_buf   = {residue_bits_r, cls[4:0]};
    sh_cnt   = 4'({1'b0, residue_count_r} + 4'd5);
    data_hit = 1'b0;
    byte_val = 8'h00;
    if (s1_valid_r && !error_flag_r) begin
      if (padding_seen_r) begin
        if (cls != b32d_pkg::CLS_PAD) err_seen = 1'b1;
      end else if (cls == b32d_pkg::CLS_PAD) begin
        padding_seen_nxt = 1'b1;
      end else if (cls == b32d_pkg::CLS_BAD) begin
        err_seen = 1'b1;
      end else if (cls < b32d_pkg::CLS_SPACE) begin
        if (sh_cnt >= 4'd8) begin
          sh_cnt   = sh_cnt - 4'd8;
          data_hit = 1'b1;
          byte_val = 8'(sh_buf >> sh_cnt);
          sh_buf   = sh_buf & 12'((12'd1 << sh_cnt) - 12'd1);
          if (bytes_out_r != '1) bytes_seen = bytes_out_r + 1'b1;
        end
        residue_bits_nxt  = sh_buf[6:0];
        residue_count_nxt = sh_cnt[2:0];
      end
    end
    error_flag_nxt = err_seen;
    bytes_out_nxt  = bytes_seen;
    // end of message clears everything for the next one
    if (s1_valid_r && s1_eot_r) begin
      residue_bits_nxt  = '0;
      residue_count_nxt = '0;
      padding_seen_nxt  = 1'b0;
      error_flag_nxt    = 1'b0;
      bytes_out_nxt     = '0;
    end
  end

  generate
    if (COUNT_BITS > 16) begin : g_clamp
      assign rep_count = (bytes_seen > COUNT_BITS'(16'hFFFF)) ? 16'hFFFF
                                                               : bytes_seen[15:0];
    end else begin : g_wide
      assign rep_count = 16'(bytes_seen);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      residue_bits_r  <= '0;
      residue_count_r <= '0;
      padding_seen_r  <= 1'b0;
      error_flag_r    <= 1'b0;
      bytes_out_r     <= '0;
    end else begin
      residue_bits_r  <= residue_bits_nxt;
      residue_count_r <= residue_count_nxt;
      padding_seen_r  <= padding_seen_nxt;
      error_flag_r    <= error_flag_nxt;
      bytes_out_r     <= bytes_out_nxt;
    end
  end

  always_comb begin
    res_b.kind       = b32d_pkg::KIND_STATUS;
    res_b.data_byte  = 8'h00;
    res_b.status     = err_seen;
    res_b.byte_count = rep_count;
    if (data_hit) begin
      res_a.kind       = b32d_pkg::KIND_DATA;
      res_a.data_byte  = byte_val;
      res_a.status     = 1'b0;
      res_a.byte_count = 16'h0000;
    end else begin
      res_a = res_b;
    end
    push.first  = s1_valid_r && (data_hit || s1_eot_r);
    push.second = s1_valid_r && data_hit && s1_eot_r;
  end

endmodule

`default_nettype wire

// ===== sv/b32d_result_fifo.sv =====
// result queue taking up to two results per cycle and giving one
`default_nettype none

module b32d_result_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire b32d_pkg::push_t push,
  input  wire b32d_pkg::res_t  res_a,
  input  wire b32d_pkg::res_t  res_b,
  input  wire logic            pop,
  output logic                 not_empty,
  output b32d_pkg::res_t       head,
  output logic [$clog2(b32d_pkg::RES_DEPTH+1)-1:0] count
);

  localparam int DEPTH = b32d_pkg::RES_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  b32d_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [PW-1:0]  wr_next_slot;

  assign wr_next_slot = wr_ptr_r + 1'b1;
  assign not_empty    = (count_r != '0);
  assign head         = mem_r[rd_ptr_r];
  assign count        = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.first) + PW'(push.second);
    count_nxt  = count_r + CW'(push.first) + CW'(push.second) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
    if (push.first)  mem_r[wr_ptr_r]     <= res_a;
    if (push.second) mem_r[wr_next_slot] <= res_b;
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// testbench for base32_stream_decoder: directed and random character streams
`default_nettype none

module tb;

  localparam int PERIOD = 12;
  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int MAX_PRINTED = 40;
  localparam longint COUNT_MAX = (64'd1 << b32d_pkg::COUNT_BITS_DEF) - 1;
  // symbols for a message whose byte count runs past eight bits
  localparam int LONG_CHARS = 416;

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_2 = 8'h32;
  localparam logic [7:0] CH_DIG_7 = 8'h37;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #(PERIOD / 2) clk = ~clk;

  b32d_in_if  in_ch ();
  b32d_out_if out_ch ();

  base32_stream_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b32d_pkg::res_t expected_words[$];
  logic [7:0] msg_chars[$];
  logic [6:0] res_bits;
  logic [2:0] res_len;
  logic       pad_seen;
  logic       bad_seen;
  longint     byte_total;
  int         mismatch_count = 0;
  int         random_sent;
  bit         steady_flow = 1'b0;

  function automatic logic [5:0] char_class(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (folded >= CH_LO_A && folded <= CH_LO_Z) return 6'(folded - CH_LO_A);
    if (c >= CH_DIG_2 && c <= CH_DIG_7) return 6'(c - CH_DIG_2 + 8'd26);
    if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) return b32d_pkg::CLS_SPACE;
    if (c == b32d_pkg::PAD_CHAR) return b32d_pkg::CLS_PAD;
    return b32d_pkg::CLS_BAD;
  endfunction

  function automatic void clear_decoder();
    res_bits = '0;
    res_len = '0;
    pad_seen = 1'b0;
    bad_seen = 1'b0;
    byte_total = 0;
  endfunction

  // expected words for one accepted character word
  function automatic void decode_char(input logic [7:0] c, input logic eot);
    logic [5:0]     cls;
    logic [11:0]    acc;
    logic [3:0]     nbits;
    b32d_pkg::res_t w;
    cls = char_class(c);
    if (!bad_seen) begin
      if (pad_seen) begin
        if (cls != b32d_pkg::CLS_PAD) bad_seen = 1'b1;
      end else if (cls == b32d_pkg::CLS_PAD) begin
        pad_seen = 1'b1;
      end else if (cls == b32d_pkg::CLS_BAD) begin
        bad_seen = 1'b1;
      end else if (cls < b32d_pkg::CLS_SPACE) begin
        acc = {res_bits, cls[4:0]};
        nbits = {1'b0, res_len} + 4'd5;
        if (nbits >= 4'd8) begin
          nbits = nbits - 4'd8;
          w = '0;
          w.kind = b32d_pkg::KIND_DATA;
          w.data_byte = 8'(acc >> nbits);
          expected_words.push_back(w);
          acc = acc & ((12'd1 << nbits) - 12'd1);
          if (byte_total < COUNT_MAX) byte_total++;
        end
        res_bits = acc[6:0];
        res_len = nbits[2:0];
      end
    end
    if (eot) begin
      w = '0;
      w.kind = b32d_pkg::KIND_STATUS;
      w.status = bad_seen;
      w.byte_count = (byte_total > 65535) ? 16'hFFFF : 16'(byte_total);
      expected_words.push_back(w);
      clear_decoder();
    end
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, field, got, want);
    end
    mismatch_count++;
  endtask

  // predict on accepted input words, check accepted result words
  always @(posedge clk) begin : check_words
    b32d_pkg::res_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing pending", {out_ch.kind, out_ch.data_byte}, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch("kind", out_ch.kind, want.kind);
          if (out_ch.data_byte !== want.data_byte)
            report_mismatch("data_byte", out_ch.data_byte, want.data_byte);
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.byte_count !== want.byte_count)
            report_mismatch("byte_count", out_ch.byte_count, want.byte_count);
        end
      end
      if (in_ch.valid && in_ch.ready) decode_char(in_ch.char_code, in_ch.end_of_text);
    end
  end

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady_flow || ($urandom_range(99) >= 9);
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (!in_ch.valid && expected_words.size() == 0)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_char(input logic [7:0] c, input logic eot);
    if (!steady_flow && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sends msg_chars, end_of_text on the last word if asked
  task automatic send_message(input logic mark_end);
    for (int i = 0; i < msg_chars.size(); i++) begin
      send_char(msg_chars[i], mark_end && (i == msg_chars.size() - 1));
    end
    random_sent += msg_chars.size();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] symbol_char(input int v);
    if (v < 26) return 8'(($urandom_range(1) ? CH_UP_A : CH_LO_A) + v);
    return 8'(CH_DIG_2 + v - 26);
  endfunction

  function automatic logic [7:0] space_char();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (char_class(c) != b32d_pkg::CLS_BAD);
    return c;
  endfunction

  task automatic test_alphabet_edges();
    msg_chars = '{CH_UP_A, CH_UP_Z, CH_LO_A, CH_LO_Z, CH_DIG_2, CH_DIG_7,
                  CH_TAB, CH_CR, CH_SPACE, b32d_pkg::PAD_CHAR, b32d_pkg::PAD_CHAR};
    send_message(1'b1);
    wait_drained();
  endtask

  task automatic test_invalid_chars();
    // top-bit code mid message, then a lone control code
    msg_chars = '{8'h42, 8'h80, 8'h43};
    send_message(1'b1);
    msg_chars = '{8'h00};
    send_message(1'b1);
    wait_drained();
  endtask

  task automatic test_after_padding();
    msg_chars = '{8'h4D, b32d_pkg::PAD_CHAR, CH_SPACE};
    send_message(1'b1);
    msg_chars = '{8'h4D, b32d_pkg::PAD_CHAR, CH_UP_A};
    send_message(1'b1);
    wait_drained();
  endtask

  task automatic test_empty_message();
    msg_chars = '{b32d_pkg::PAD_CHAR};
    send_message(1'b1);
    msg_chars = '{CH_SPACE};
    send_message(1'b1);
    wait_drained();
  endtask

  // ten bits: the last word completes a byte and closes the message
  task automatic test_byte_on_last();
    msg_chars = '{CH_DIG_7, CH_DIG_7};
    send_message(1'b1);
    wait_drained();
  endtask

  task automatic test_long_message();
    for (int i = 0; i < LONG_CHARS; i++) begin
      send_char(symbol_char($urandom_range(31)), 1'b0);
    end
    send_char(b32d_pkg::PAD_CHAR, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_messages();
    int pick;
    int pads;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      steady_flow = (random_sent >= 600 && random_sent < 900);
      msg_chars.delete();
      pick = $urandom_range(99);
      if (pick < 8) begin
        // raw noise, sometimes left open into the next message
        repeat ($urandom_range(4, 1)) msg_chars.push_back(8'($urandom_range(255)));
        send_message(1'b1 & $urandom_range(1));
      end else begin
        repeat ($urandom_range(1) ? $urandom_range(8) : $urandom_range(40)) begin
          if ($urandom_range(9) == 0) msg_chars.push_back(space_char());
          msg_chars.push_back(symbol_char($urandom_range(31)));
        end
        if ($urandom_range(1)) begin
          pads = $urandom_range(6, 1);
          repeat (pads) msg_chars.push_back(b32d_pkg::PAD_CHAR);
        end
        if (pick < 14) begin
          msg_chars.insert($urandom_range(msg_chars.size()), bad_char());
        end else if (pick < 20) begin
          msg_chars.push_back(b32d_pkg::PAD_CHAR);
          msg_chars.push_back($urandom_range(1) ? space_char()
                                                : symbol_char($urandom_range(31)));
        end
        if (msg_chars.size() == 0) begin
          msg_chars.push_back($urandom_range(1) ? b32d_pkg::PAD_CHAR : space_char());
        end
        send_message(1'b1);
      end
    end
    steady_flow = 1'b0;
    // close any message left open by noise
    msg_chars = '{CH_SPACE};
    send_message(1'b1);
    wait_drained();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.end_of_text <= 1'b0;
    clear_decoder();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alphabet_edges();
    test_invalid_chars();
    test_after_padding();
    test_empty_message();
    test_byte_on_last();
    test_random_messages();
    test_long_message();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
